@@ rtl/equatorial_to_galactic_converter_top_macros.svh @@
// Assertion macros shared by the project.
`ifndef EQUATORIAL_TO_GALACTIC_CONVERTER_TOP_MACROS_SVH
`define EQUATORIAL_TO_GALACTIC_CONVERTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define EQG_ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define EQG_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define EQG_ASSERT_IMPLIES(label, clk, rst, a, b)
`define EQG_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

@@ rtl/eqg_pkg.sv @@
package eqg_pkg;

  localparam int Z_W               = 34;
  localparam int DEF_CORDIC_STAGES = 20;
  localparam int DEF_FRAC_BITS     = 16;

  localparam logic [22:0]        RA_DAY   = 23'd6291456;
  localparam logic signed [23:0] LAT_MAX  = 24'sd5898240;
  localparam logic [24:0]        LON_FULL = 25'd23592960;

  localparam logic [23:0] M3  = 24'd11184811;
  localparam logic [23:0] M45 = 24'd11930465;
  localparam logic [20:0] M90 = 21'd1491309;

  localparam logic signed [Z_W-1:0] HALF_TURN_Z = Z_W'(64'd2147483648);

  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned Q_HALF  = 64'd5000000000;
  localparam longint unsigned Q_DEN   = 64'd10000000000;

  localparam longint GAIN_Q30 = longint'((64'd6072529350 * Q30_ONE + Q_HALF) / Q_DEN);
  localparam logic signed [31:0] GAIN_S = 32'(GAIN_Q30);

  localparam logic [31:0] AGM_00 = 32'((64'd548755604 * Q30_ONE + Q_HALF) / Q_DEN);
  localparam logic [31:0] AGM_01 = 32'((64'd4941094279 * Q30_ONE + Q_HALF) / Q_DEN);
  localparam logic [31:0] AGM_02 = 32'((64'd8676661490 * Q30_ONE + Q_HALF) / Q_DEN);
  localparam logic [31:0] AGM_10 = 32'((64'd8734370902 * Q30_ONE + Q_HALF) / Q_DEN);
  localparam logic [31:0] AGM_11 = 32'((64'd4448296300 * Q30_ONE + Q_HALF) / Q_DEN);
  localparam logic [31:0] AGM_12 = 32'((64'd1980763734 * Q30_ONE + Q_HALF) / Q_DEN);
  localparam logic [31:0] AGM_20 = 32'((64'd4838350155 * Q30_ONE + Q_HALF) / Q_DEN);
  localparam logic [31:0] AGM_21 = 32'((64'd7469822445 * Q30_ONE + Q_HALF) / Q_DEN);
  localparam logic [31:0] AGM_22 = 32'((64'd4559837762 * Q30_ONE + Q_HALF) / Q_DEN);

  localparam logic signed [31:0] AG [3][3] = '{
    '{32'sd0 - $signed(AGM_00), $signed(AGM_01), 32'sd0 - $signed(AGM_02)},
    '{32'sd0 - $signed(AGM_10), 32'sd0 - $signed(AGM_11), 32'sd0 - $signed(AGM_12)},
    '{32'sd0 - $signed(AGM_20), $signed(AGM_21), $signed(AGM_22)}
  };

  function automatic logic [31:0] atan_angle(input int idx);
    logic [31:0] a;
    case (idx)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      24: a = 32'd41;
      25: a = 32'd20;
      26: a = 32'd10;
      27: a = 32'd5;
      28: a = 32'd3;
      29: a = 32'd1;
      30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // fraction of the right ascension angle left over after dividing by three
  function automatic logic [10:0] ra_frac(input logic [1:0] r);
    logic [10:0] f;
    case (r)
      2'd1:    f = 11'd683;
      2'd2:    f = 11'd1365;
      default: f = 11'd0;
    endcase
    return f;
  endfunction

endpackage

@@ rtl/eqg_cordic_cell.sv @@
module eqg_cordic_cell
  import eqg_pkg::*;
#(
  parameter int W         = DEF_FRAC_BITS + 3,
  parameter int SBW       = 1,
  parameter int SHIFT     = 0,
  parameter bit VECTORING = 1'b0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic signed [W-1:0]   x_in,
  input  logic signed [W-1:0]   y_in,
  input  logic signed [Z_W-1:0] z_in,
  input  logic [SBW-1:0]        sb_in,
  output logic signed [W-1:0]   x,
  output logic signed [W-1:0]   y,
  output logic signed [Z_W-1:0] z,
  output logic [SBW-1:0]        sb
);

  localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_angle(SHIFT));

  logic signed [W-1:0] xs, ys;
  logic                ccw;

  assign xs  = x_in >>> SHIFT;
  assign ys  = y_in >>> SHIFT;
  assign ccw = VECTORING ? !(y_in > 0) : !z_in[Z_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      x <= ccw ? x_in - ys : x_in + ys;
      y <= ccw ? y_in + xs : y_in - xs;
      z <= ccw ? z_in - ATAN : z_in + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sb <= '0;
    end else if (en) begin
      sb <= sb_in;
    end
  end

endmodule

@@ rtl/eqg_cordic.sv @@
module eqg_cordic
  import eqg_pkg::*;
#(
  parameter int STAGES    = DEF_CORDIC_STAGES,
  parameter int W         = DEF_FRAC_BITS + 3,
  parameter int SBW       = 1,
  parameter bit VECTORING = 1'b0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic signed [W-1:0]   x_in,
  input  logic signed [W-1:0]   y_in,
  input  logic signed [Z_W-1:0] z_in,
  input  logic [SBW-1:0]        sb_in,
  output logic signed [W-1:0]   x,
  output logic signed [W-1:0]   y,
  output logic signed [Z_W-1:0] z,
  output logic [SBW-1:0]        sb
);

  logic signed [W-1:0]   xa  [STAGES+1];
  logic signed [W-1:0]   ya  [STAGES+1];
  logic signed [Z_W-1:0] za  [STAGES+1];
  logic [SBW-1:0]        sba [STAGES+1];

  assign xa[0]  = x_in;
  assign ya[0]  = y_in;
  assign za[0]  = z_in;
  assign sba[0] = sb_in;

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    eqg_cordic_cell #(
      .W(W), .SBW(SBW), .SHIFT(i), .VECTORING(VECTORING)
    ) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .x_in(xa[i]), .y_in(ya[i]), .z_in(za[i]), .sb_in(sba[i]),
      .x(xa[i+1]), .y(ya[i+1]), .z(za[i+1]), .sb(sba[i+1])
    );
  end

  assign x  = xa[STAGES];
  assign y  = ya[STAGES];
  assign z  = za[STAGES];
  assign sb = sba[STAGES];

endmodule

@@ rtl/equatorial_to_galactic_converter_top.sv @@
// Throughput: one beat per cycle while the output stage has room; three chains of
// CORDIC cells in series (20 stages each by default) set most of the depth.
// A two-entry output stage keeps accepting while one result waits to be taken;
// once both entries are full it stalls the pipeline and drops s_axis_tready.
// Reset (rst, synchronous) empties the pipeline and the output stage.
`include "equatorial_to_galactic_converter_top_macros.svh"
module equatorial_to_galactic_converter_top
  import eqg_pkg::*;
#(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
  parameter int FRAC_BITS     = DEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // ra_hours[22:0], dec_degrees[46:23]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // gal_longitude[24:0], gal_latitude[48:25]
);

  localparam int W = FRAC_BITS + 3;
  localparam logic signed [W-1:0] X0 = W'(GAIN_Q30 >>> (30 - FRAC_BITS));

  logic       en;
  logic [6:1] v;

  logic [22:0]        ra_in;
  logic signed [23:0] dec_in, dec_c;
  assign ra_in  = s_axis_tdata[22:0];
  assign dec_in = s_axis_tdata[46:23];
  assign dec_c  = (dec_in > LAT_MAX) ? LAT_MAX :
                  (dec_in < -LAT_MAX) ? -LAT_MAX : dec_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:1], s_axis_tvalid};
    end
  end

  logic [22:0] ra_w, mdec;
  logic        dneg;
  logic [20:0] raq;
  logic [17:0] dq;
  logic [22:0] ra_w2, mdec2;
  logic        dneg2;
  logic [1:0]  rar;
  logic [5:0]  dr_c, dr;
  logic [31:0] ra_ang3;
  logic [17:0] dq3;
  logic        dneg3;
  logic [19:0] dv;
  logic [12:0] dq90;
  logic [17:0] dq4;
  logic        dneg4;
  logic [31:0] ra_ang4;
  logic [30:0] b;
  logic [31:0] ra_ang5, dec_ang5;
  logic signed [31:0] za, zb;
  logic        fa, fb;

  assign rar  = 2'(ra_w2 - 23'(raq) * 23'd3);
  assign dr_c = 6'(mdec2 - 23'(dq) * 23'd45);
  assign dv   = {dr, 14'b0} + 20'd45;
  assign b    = {dq4, 13'b0} + 31'(dq90);

  always_ff @(posedge clk) begin
    if (en) begin
      ra_w     <= (ra_in >= RA_DAY) ? ra_in - RA_DAY : ra_in;
      mdec     <= dec_c[23] ? 23'(-dec_c) : 23'(dec_c);
      dneg     <= dec_c[23];
      raq      <= 21'((48'(ra_w) * 48'(M3)) >> 25);
      dq       <= 18'((48'(mdec) * 48'(M45)) >> 29);
      ra_w2    <= ra_w;
      mdec2    <= mdec;
      dneg2    <= dneg;
      ra_ang3  <= {raq, 11'b0} + 32'(ra_frac(rar));
      dr       <= dr_c;
      dq3      <= dq;
      dneg3    <= dneg2;
      dq90     <= 13'((41'(dv) * 41'(M90)) >> 27);
      dq4      <= dq3;
      dneg4    <= dneg3;
      ra_ang4  <= ra_ang3;
      ra_ang5  <= ra_ang4;
      dec_ang5 <= dneg4 ? 32'd0 - 32'(b) : 32'(b);
      // fold into the right half plane, flip the result later
      za <= {ra_ang5[31] ^ (ra_ang5[31] ^ ra_ang5[30]), ra_ang5[30:0]};
      fa <= ra_ang5[31] ^ ra_ang5[30];
      zb <= {dec_ang5[31] ^ (dec_ang5[31] ^ dec_ang5[30]), dec_ang5[30:0]};
      fb <= dec_ang5[31] ^ dec_ang5[30];
    end
  end

  logic signed [W-1:0] ca_x, ca_y, cb_x, cb_y;
  logic [1:0]          sba;
  logic                sbb;

  eqg_cordic #(.STAGES(CORDIC_STAGES), .W(W), .SBW(2), .VECTORING(1'b0)) u_rot_ra (
    .clk(clk), .rst(rst), .en(en),
    .x_in(X0), .y_in('0), .z_in(Z_W'(za)), .sb_in({v[6], fa}),
    .x(ca_x), .y(ca_y), .z(), .sb(sba)
  );

  eqg_cordic #(.STAGES(CORDIC_STAGES), .W(W), .SBW(1), .VECTORING(1'b0)) u_rot_dec (
    .clk(clk), .rst(rst), .en(en),
    .x_in(X0), .y_in('0), .z_in(Z_W'(zb)), .sb_in(fb),
    .x(cb_x), .y(cb_y), .z(), .sb(sbb)
  );

  logic                  v7, v8, v9, v10;
  logic signed [W-1:0]   cr, sr, cd, sd;
  logic signed [W-1:0]   p [3];
  logic signed [W+31:0]  mp [3][3];
  logic signed [W-1:0]   g [3];
  logic signed [2*W-1:0] m0, m1;

  assign m0 = cd * cr;
  assign m1 = cd * sr;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else if (en) begin
      v7  <= sba[1];
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cr   <= sba[0] ? -ca_x : ca_x;
      sr   <= sba[0] ? -ca_y : ca_y;
      cd   <= sbb ? -cb_x : cb_x;
      sd   <= sbb ? -cb_y : cb_y;
      p[0] <= W'(m0 >>> FRAC_BITS);
      p[1] <= W'(m1 >>> FRAC_BITS);
      p[2] <= sd;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mp[i][j] <= (W+32)'(AG[i][j]) * (W+32)'(p[i]);
        end
      end
      for (int j = 0; j < 3; j++) begin
        g[j] <= W'(((W+34)'(mp[0][j]) + (W+34)'(mp[1][j]) + (W+34)'(mp[2][j])) >>> 30);
      end
    end
  end

  logic                  g0neg, pole;
  logic signed [W-1:0]   v1x, v1y;
  logic signed [Z_W-1:0] v1z;

  assign g0neg = g[0][W-1];
  assign v1x   = g0neg ? -g[0] : g[0];
  assign v1y   = g0neg ? -g[1] : g[1];
  assign v1z   = g0neg ? HALF_TURN_Z : '0;
  assign pole  = (g[0] == 0) && (g[1] == 0);

  logic signed [W-1:0]   m1x;
  logic signed [Z_W-1:0] m1z;
  logic [W+1:0]          sb1;

  eqg_cordic #(.STAGES(CORDIC_STAGES), .W(W), .SBW(W+2), .VECTORING(1'b1)) u_vec_lon (
    .clk(clk), .rst(rst), .en(en),
    .x_in(v1x), .y_in(v1y), .z_in(v1z), .sb_in({v10, pole, g[2]}),
    .x(m1x), .y(), .z(m1z), .sb(sb1)
  );

  logic [31:0]         lon_ang;
  logic [24:0]         lon_raw, lon13;
  logic signed [W-1:0] xy, g2_13;
  logic signed [W+31:0] xyp;
  logic                v13;

  assign lon_ang = sb1[W] ? 32'd0 : m1z[31:0];
  assign lon_raw = 25'((41'(lon_ang) * 41'd360 + 41'd32768) >> 16);
  assign xyp     = (W+32)'(m1x) * (W+32)'(GAIN_S);

  always_ff @(posedge clk) begin
    if (rst) begin
      v13 <= 1'b0;
    end else if (en) begin
      v13 <= sb1[W+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xy    <= sb1[W] ? '0 : W'(xyp >>> 30);
      lon13 <= (lon_raw >= LON_FULL) ? lon_raw - LON_FULL : lon_raw;
      g2_13 <= sb1[W-1:0];
    end
  end

  logic                  zero13;
  logic signed [Z_W-1:0] z2;
  logic [26:0]           sb2;

  assign zero13 = (xy == 0) && (g2_13 == 0);

  eqg_cordic #(.STAGES(CORDIC_STAGES), .W(W), .SBW(27), .VECTORING(1'b1)) u_vec_lat (
    .clk(clk), .rst(rst), .en(en),
    .x_in(xy), .y_in(g2_13), .z_in('0), .sb_in({v13, zero13, lon13}),
    .x(), .y(), .z(z2), .sb(sb2)
  );

  logic signed [Z_W+10:0] lat_full, lat_sh;
  logic signed [23:0]     lat_new;

  assign lat_full = (Z_W+11)'(z2) * (Z_W+11)'(360) + (Z_W+11)'(32768);
  assign lat_sh   = lat_full >>> 16;
  assign lat_new  = sb2[25] ? 24'sd0 :
                    (lat_sh > (Z_W+11)'(LAT_MAX)) ? LAT_MAX :
                    (lat_sh < -(Z_W+11)'(LAT_MAX)) ? -LAT_MAX : 24'(lat_sh);

  logic               out_valid, spare_valid, take;
  logic [24:0]        out_lon, spare_lon;
  logic signed [23:0] out_lat, spare_lat;

  assign en    = !spare_valid;
  assign take  = out_valid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (spare_valid) begin
      if (take) begin
        out_lon     <= spare_lon;
        out_lat     <= spare_lat;
        spare_valid <= 1'b0;
      end
    end else if (sb2[26]) begin
      if (!out_valid || take) begin
        out_lon   <= sb2[24:0];
        out_lat   <= lat_new;
        out_valid <= 1'b1;
      end else begin
        spare_lon   <= sb2[24:0];
        spare_lat   <= lat_new;
        spare_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_lat, out_lon};

  `EQG_ASSERT_IMPLIES(a_spare_needs_out, clk, rst, spare_valid, out_valid)
  `EQG_ASSERT_NEXT(a_spare_holds, clk, rst, spare_valid && !m_axis_tready, spare_valid)
  `EQG_ASSERT_IMPLIES(a_lon_range, clk, rst, out_valid, out_lon < LON_FULL)
  `EQG_ASSERT_IMPLIES(a_lat_range, clk, rst, out_valid, (out_lat <= LAT_MAX) && (out_lat >= -LAT_MAX))

endmodule

@@ tb/tb_equatorial_to_galactic_converter_top.sv @@
class galactic_rotation_book;
  typedef struct packed {
    logic [24:0]        lon;
    logic signed [23:0] lat;
  } gal_coord_t;

  localparam int STAGES = 20;
  localparam int FB     = 16;
  localparam longint HALF  = 64'sd2147483648;
  localparam longint QUART = 64'sd1073741824;

  gal_coord_t pending_coords[$];
  int         mismatches;
  longint     rot[3][3];
  longint     gain;
  longint     arc[STAGES];

  function new();
    longint unsigned mags[3][3];
    int sgn[3][3];
    mags = '{'{64'd548755604, 64'd4941094279, 64'd8676661490},
             '{64'd8734370902, 64'd4448296300, 64'd1980763734},
             '{64'd4838350155, 64'd7469822445, 64'd4559837762}};
    sgn  = '{'{-1, 1, -1}, '{-1, -1, -1}, '{-1, 1, 1}};
    foreach (rot[i, j]) rot[i][j] = sgn[i][j] * longint'(to_q30(mags[i][j]));
    gain = longint'(to_q30(64'd6072529350));
    arc = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304};
    mismatches = 0;
  endfunction

  function longint unsigned to_q30(longint unsigned n);
    return (n * 64'd1073741824 + 64'd5000000000) / 64'd10000000000;
  endfunction

  function void sin_cos(longint unsigned ang, output longint c, output longint s);
    longint z, x, y, nx;
    bit flip;
    z = ang >= 64'h80000000 ? longint'(ang) - 64'sd4294967296 : longint'(ang);
    flip = 0;
    if (z >= QUART || z < -QUART) begin
      z = z >= 0 ? z - HALF : z + HALF;
      flip = 1;
    end
    x = gain >>> (30 - FB);
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= arc[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += arc[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function longint vector_angle(longint x, longint y, output longint mag);
    longint z, nx;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = HALF;
    end
    for (int i = 0; i < STAGES; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z += arc[i];
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= arc[i];
      end
      x = nx;
    end
    mag = x;
    return z;
  endfunction

  function void note_radec(logic [22:0] ra_in, logic [23:0] dec_in);
    longint unsigned ra, ra_ang, dec_ang, lon_ang, lon;
    longint dec, m, b, cr, sr, cd, sd, mag, xy, zl, lat, acc;
    longint p[3], g[3];
    gal_coord_t e;
    ra = ra_in;
    if (ra >= 64'd6291456) ra -= 64'd6291456;
    ra_ang = ((ra * 16384 + 12) / 24) & 64'hFFFFFFFF;
    dec = longint'($signed(dec_in));
    if (dec > 5898240) dec = 5898240;
    if (dec < -5898240) dec = -5898240;
    m = dec < 0 ? -dec : dec;
    b = (m * 65536 + 180) / 360;
    if (dec < 0) b = -b;
    dec_ang = longint'(b) & 64'hFFFFFFFF;
    sin_cos(ra_ang, cr, sr);
    sin_cos(dec_ang, cd, sd);
    p[0] = (cd * cr) >>> FB;
    p[1] = (cd * sr) >>> FB;
    p[2] = sd;
    for (int j = 0; j < 3; j++) begin
      acc = 0;
      for (int i = 0; i < 3; i++) acc += rot[i][j] * p[i];
      g[j] = acc >>> 30;
    end
    if (g[0] == 0 && g[1] == 0) begin
      lon_ang = 0;
      xy = 0;
    end else begin
      lon_ang = longint'(vector_angle(g[0], g[1], mag)) & 64'hFFFFFFFF;
      xy = (mag * gain) >>> 30;
    end
    lon = (lon_ang * 360 + 32768) >> 16;
    if (lon >= 64'd23592960) lon -= 64'd23592960;
    if (xy == 0 && g[2] == 0) begin
      lat = 0;
    end else begin
      zl = vector_angle(xy, g[2], mag);
      lat = (zl * 360 + 32768) >>> 16;
      if (lat > 5898240) lat = 5898240;
      if (lat < -5898240) lat = -5898240;
    end
    e.lon = lon[24:0];
    e.lat = lat[23:0];
    pending_coords.push_back(e);
  endfunction

  function void check_galactic(logic [24:0] lon, logic [23:0] lat);
    gal_coord_t e;
    if (pending_coords.size() == 0) begin
      $display("%0t: unexpected beat lon=%0d lat=%0d", $time, lon, $signed(lat));
      mismatches++;
      return;
    end
    e = pending_coords.pop_front();
    if (lon !== e.lon) begin
      $display("%0t: gal_longitude expected %0d actual %0d", $time, e.lon, lon);
      mismatches++;
    end
    if (lat !== e.lat) begin
      $display("%0t: gal_latitude expected %0d actual %0d", $time, e.lat, $signed(lat));
      mismatches++;
    end
  endfunction
endclass

module tb_equatorial_to_galactic_converter_top;
  import eqg_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [55:0] m_axis_tdata;

  galactic_rotation_book book = new();
  int sink_mode = 0;
  int sink_count = 0;

  equatorial_to_galactic_converter_top i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      book.check_galactic(m_axis_tdata[24:0], m_axis_tdata[48:25]);
    sink_count <= sink_count + 1;
    if (sink_count % 97 == 0) sink_mode <= $urandom_range(0, 3);
    case (sink_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      2: m_axis_tready <= ($urandom_range(0, 5) == 0);
      default: m_axis_tready <= ((sink_count / 7) % 2 == 0);
    endcase
  end

  task automatic push_beat(logic [22:0] ra, logic [23:0] dec);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, dec, ra};
    do @(posedge clk); while (!s_axis_tready);
    book.note_radec(ra, dec);
  endtask

  task automatic pause_source(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    logic [22:0] ra_edge[5];
    logic [23:0] dec_edge[5];
    logic [22:0] ra;
    logic [23:0] dec;
    int burst;
    int sent;
    ra_edge  = '{23'd0, 23'd1, 23'd6291455, 23'd6291456, 23'h7FFFFF};
    dec_edge = '{24'd0, 24'd5898240, -24'sd5898240, 24'h7FFFFF, 24'h800000};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (ra_edge[i])
      foreach (dec_edge[j]) push_beat(ra_edge[i], dec_edge[j]);
    pause_source(3);
    sent = 0;
    while (sent < 1100) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) begin
        if ($urandom_range(0, 9) < 7) begin
          ra  = 23'($urandom_range(0, 6291455));
          dec = 24'($urandom_range(0, 11796480) - 5898240);
        end else begin
          ra  = 23'($urandom);
          dec = 24'($urandom);
        end
        push_beat(ra, dec);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_source($urandom_range(1, 12));
    end
    s_axis_tvalid <= 1'b0;
    while (book.pending_coords.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (book.mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl
rtl/eqg_pkg.sv
rtl/eqg_cordic_cell.sv
rtl/eqg_cordic.sv
rtl/equatorial_to_galactic_converter_top.sv
tb/tb_equatorial_to_galactic_converter_top.sv
